@@ src/knn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knn_pkg: shared constants
// Widths, op, label and status codes, and the reset value of k for the
// one-dimensional nearest-neighbor vote classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

   localparam int CapacityDefault  = 256;
   localparam int ValueBitsDefault = 32;
   localparam int LabelBits        = 2;
   localparam int CountBits        = 9;
   localparam int KBits            = 4;
   localparam int OpBits           = 1;
   localparam int StatusBits       = 2;

   localparam logic [KBits-1:0] KReset = 4'd3;

   localparam logic [OpBits-1:0] OP_INSERT   = 1'b0;
   localparam logic [OpBits-1:0] OP_CLASSIFY = 1'b1;

   localparam logic [LabelBits-1:0] LABEL_PASS    = 2'd0;
   localparam logic [LabelBits-1:0] LABEL_UNKNOWN = 2'd1;
   localparam logic [LabelBits-1:0] LABEL_FAIL    = 2'd2;

   localparam logic [StatusBits-1:0] ST_OK   = 2'd0;
   localparam logic [StatusBits-1:0] ST_DUP  = 2'd1;
   localparam logic [StatusBits-1:0] ST_FULL = 2'd2;

endpackage : knn_pkg
`default_nettype wire

@@ src/knn_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knn_req_if / knn_rsp_if: ready/valid channels
// Request channel carries op, value and label; response channel carries the
// verdict, status and entry count.
// ----------------------------------------------------------------------------
interface knn_req_if #(
   parameter int VALUE_BITS = knn_pkg::ValueBitsDefault
);
   logic                              valid;
   logic                              ready;
   logic [knn_pkg::OpBits-1:0]        op;
   logic signed [VALUE_BITS-1:0]      sample_value;
   logic [knn_pkg::LabelBits-1:0]     sample_label;

   modport source (output valid, op, sample_value, sample_label, input ready);
   modport sink   (input valid, op, sample_value, sample_label, output ready);
endinterface : knn_req_if

interface knn_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [knn_pkg::LabelBits-1:0]     outcome;
   logic [knn_pkg::StatusBits-1:0]    status;
   logic [knn_pkg::CountBits-1:0]     entry_count;

   modport source (output valid, outcome, status, entry_count, input ready);
   modport sink   (input valid, outcome, status, entry_count, output ready);
endinterface : knn_rsp_if
`default_nettype wire

@@ src/knn_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knn_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module knn_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule : knn_ram
`default_nettype wire

@@ src/knn_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knn_seq: sequencer for search, insert shift and neighbor walk
// Drives the single RAM port and separate left and right distance paths. Every
// RAM read is a request state followed by a data state; writes need no data state.
// ----------------------------------------------------------------------------
module knn_seq #(
   parameter int CAPACITY   = knn_pkg::CapacityDefault,
   parameter int VALUE_BITS = knn_pkg::ValueBitsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [knn_pkg::KBits-1:0]          csr_wdata,
   knn_req_if.sink                                 req,
   knn_rsp_if.source                               rsp,
   output logic                                    ram_we,
   output logic [$clog2(CAPACITY)-1:0]             ram_addr,
   output logic [VALUE_BITS+knn_pkg::LabelBits-1:0] ram_wdata,
   input  wire logic [VALUE_BITS+knn_pkg::LabelBits-1:0] ram_rdata
);
   import knn_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int NW = $clog2(CAPACITY + 1);
   localparam int EW = VALUE_BITS + LabelBits;
   localparam int DW = VALUE_BITS + 1;
   localparam logic [NW-1:0] CapN = NW'(CAPACITY);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BREQ  = 4'd1;
   localparam logic [3:0] S_BDAT  = 4'd2;
   localparam logic [3:0] S_DREQ  = 4'd3;
   localparam logic [3:0] S_DDAT  = 4'd4;
   localparam logic [3:0] S_SREQ  = 4'd5;
   localparam logic [3:0] S_SDAT  = 4'd6;
   localparam logic [3:0] S_WPUT  = 4'd7;
   localparam logic [3:0] S_LREQ  = 4'd8;
   localparam logic [3:0] S_LDAT  = 4'd9;
   localparam logic [3:0] S_RREQ  = 4'd10;
   localparam logic [3:0] S_RDAT  = 4'd11;
   localparam logic [3:0] S_PICK  = 4'd12;
   localparam logic [3:0] S_VOTE  = 4'd13;
   localparam logic [3:0] S_RESP  = 4'd14;

   logic [3:0]            state_ff, state_in;
   logic [KBits-1:0]      k_ff, k_in;
   logic [NW-1:0]         count_ff, count_in;
   logic [OpBits-1:0]     op_ff, op_in;
   logic signed [VALUE_BITS-1:0] val_ff, val_in;
   logic [LabelBits-1:0]  lab_ff, lab_in;
   logic [NW-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0]         idx_ff, idx_in;    // shift cursor
   logic signed [NW:0]    left_ff, left_in;
   logic [NW-1:0]         right_ff, right_in;
   logic [KBits-1:0]      taken_ff, taken_in;
   logic [KBits:0]        fails_ff, fails_in;
   logic [EW-1:0]         lent_ff, lent_in, rent_ff, rent_in;
   logic [LabelBits-1:0]  out_ff, out_in;
   logic [StatusBits-1:0] st_ff, st_in;

   logic [NW-1:0]         mid;
   logic signed [VALUE_BITS-1:0] ent_val;
   logic [LabelBits-1:0]  ent_lab, key_lab;
   logic                  below;
   logic signed [VALUE_BITS-1:0] lval, rval;
   logic [DW-1:0]         ldist, rdist;
   logic                  lv, rv, take_left;
   logic [KBits+1:0]      twice;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign ent_val = ram_rdata[EW-1:LabelBits];
   assign ent_lab = ram_rdata[LabelBits-1:0];
   assign key_lab = (op_ff == OP_CLASSIFY) ? LABEL_UNKNOWN : lab_ff;
   assign below   = (ent_val != val_ff) ? (ent_val < val_ff) : (ent_lab < key_lab);

   // Left and right distance paths: exact absolute difference on one extra bit.
   assign lval  = lent_ff[EW-1:LabelBits];
   assign rval  = rent_ff[EW-1:LabelBits];
   assign ldist = (val_ff >= lval) ? DW'({val_ff[VALUE_BITS-1], val_ff} - {lval[VALUE_BITS-1], lval})
                                   : DW'({lval[VALUE_BITS-1], lval} - {val_ff[VALUE_BITS-1], val_ff});
   assign rdist = (val_ff >= rval) ? DW'({val_ff[VALUE_BITS-1], val_ff} - {rval[VALUE_BITS-1], rval})
                                   : DW'({rval[VALUE_BITS-1], rval} - {val_ff[VALUE_BITS-1], val_ff});
   assign lv = !left_ff[NW];
   assign rv = right_ff < count_ff;
   assign take_left = lv && (!rv || (ldist < rdist));
   assign twice = {fails_ff, 1'b0};

   always_comb begin
      state_in = state_ff;
      k_in     = csr_write ? csr_wdata : k_ff;
      count_in = count_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      lab_in   = lab_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      left_in  = left_ff;
      right_in = right_ff;
      taken_in = taken_ff;
      fails_in = fails_ff;
      lent_in  = lent_ff;
      rent_in  = rent_ff;
      out_in   = out_ff;
      st_in    = st_ff;
      ram_we   = 1'b0;
      ram_addr = '0;
      ram_wdata = {val_ff, lab_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in  = req.op;
               val_in = req.sample_value;
               lab_in = req.sample_label;
               lo_in  = '0;
               hi_in  = count_ff;
               out_in = LABEL_UNKNOWN;
               st_in  = ST_OK;
               if (req.op == OP_CLASSIFY &&
                   (count_ff == '0 || NW'(k_ff) > count_ff)) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_BREQ;
               end
            end
         end
         S_BREQ: begin
            if (lo_ff < hi_ff) begin
               ram_addr = mid[AW-1:0];
               state_in = S_BDAT;
            end else if (op_ff == OP_CLASSIFY) begin
               if (lo_ff == count_ff) begin
                  left_in  = {1'b0, count_ff} - 1'b1;
                  right_in = count_ff;
               end else begin
                  left_in  = {1'b0, lo_ff};
                  right_in = lo_ff + 1'b1;
               end
               taken_in = '0;
               fails_in = '0;
               state_in = S_LREQ;
            end else begin
               state_in = S_DREQ;
            end
         end
         S_BDAT: begin
            if (below) lo_in = mid + 1'b1;
            else       hi_in = mid;
            state_in = S_BREQ;
         end
         S_DREQ: begin
            if (lo_ff < count_ff) begin
               ram_addr = lo_ff[AW-1:0];
               state_in = S_DDAT;
            end else if (count_ff >= CapN) begin
               st_in = ST_FULL;
               state_in = S_RESP;
            end else begin
               idx_in = count_ff;
               state_in = S_SREQ;
            end
         end
         S_DDAT: begin
            if (ent_val == val_ff && ent_lab == lab_ff) begin
               st_in = ST_DUP;
               state_in = S_RESP;
            end else if (count_ff >= CapN) begin
               st_in = ST_FULL;
               state_in = S_RESP;
            end else begin
               idx_in = count_ff;
               state_in = S_SREQ;
            end
         end
         // Shift entries up one place from the top down to the insert point.
         S_SREQ: begin
            if (idx_ff == lo_ff) begin
               state_in = S_WPUT;
            end else begin
               ram_addr = AW'(idx_ff - 1'b1);
               state_in = S_SDAT;
            end
         end
         S_SDAT: begin
            ram_we    = 1'b1;
            ram_addr  = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_ff - 1'b1;
            state_in  = S_SREQ;
         end
         S_WPUT: begin
            ram_we   = 1'b1;
            ram_addr = lo_ff[AW-1:0];
            count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end
         S_LREQ: begin
            if (taken_ff == k_ff) begin
               state_in = S_VOTE;
            end else if (lv) begin
               ram_addr = left_ff[AW-1:0];
               state_in = S_LDAT;
            end else begin
               state_in = S_RREQ;
            end
         end
         S_LDAT: begin
            lent_in  = ram_rdata;
            state_in = S_RREQ;
         end
         S_RREQ: begin
            if (rv) begin
               ram_addr = right_ff[AW-1:0];
               state_in = S_RDAT;
            end else begin
               state_in = S_PICK;
            end
         end
         S_RDAT: begin
            rent_in  = ram_rdata;
            state_in = S_PICK;
         end
         S_PICK: begin
            if (!lv && !rv) begin
               state_in = S_VOTE;
            end else begin
               if (take_left) begin
                  if (lent_ff[LabelBits-1:0] == LABEL_FAIL) fails_in = fails_ff + 1'b1;
                  left_in = left_ff - 1'b1;
               end else begin
                  if (rent_ff[LabelBits-1:0] == LABEL_FAIL) fails_in = fails_ff + 1'b1;
                  right_in = right_ff + 1'b1;
               end
               taken_in = taken_ff + 1'b1;
               state_in = S_LREQ;
            end
         end
         S_VOTE: begin
            if (twice > {2'b00, k_ff})      out_in = LABEL_FAIL;
            else if (twice < {2'b00, k_ff}) out_in = LABEL_PASS;
            else                            out_in = LABEL_UNKNOWN;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= KReset;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         count_ff <= count_in;
      end
      op_ff    <= op_in;
      val_ff   <= val_in;
      lab_ff   <= lab_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      idx_ff   <= idx_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      taken_ff <= taken_in;
      fails_ff <= fails_in;
      lent_ff  <= lent_in;
      rent_ff  <= rent_in;
      out_ff   <= out_in;
      st_ff    <= st_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_RESP);
   assign rsp.outcome     = out_ff;
   assign rsp.status      = st_ff;
   assign rsp.entry_count = CountBits'(count_ff);
endmodule : knn_seq
`default_nettype wire

@@ src/knn_1d_vote_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// knn_1d_vote_classifier: one-dimensional nearest-neighbor vote classifier
// Sorted sample table in RAM; inserts and queries under one sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | op, sample_value, sample_label
//  rsp     | out       | outcome, status, entry_count
//  csr     | in        | neighbor_count (write only)
//
// One item at a time. Each RAM read is a request state then a data state on the
// single port: search is a binary search, an insert shifts each entry above the
// insert point up one place, and a query walks up to k neighbors out from the key.
// Reset is synchronous; it clears the entry count and sets k to 3. The table
// needs no clearing pass. A stalled response holds the block until transfer.
module knn_1d_vote_classifier #(
   parameter int CAPACITY   = knn_pkg::CapacityDefault,
   parameter int VALUE_BITS = knn_pkg::ValueBitsDefault
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [knn_pkg::KBits-1:0] csr_wdata,
   knn_req_if.sink                        req,
   knn_rsp_if.source                      rsp
);
   import knn_pkg::*;

   localparam int EW = VALUE_BITS + LabelBits;

   logic                        ram_we;
   logic [$clog2(CAPACITY)-1:0] ram_addr;
   logic [EW-1:0]               ram_wdata, ram_rdata;

   knn_seq #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_seq (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req(req), .rsp(rsp), .ram_we(ram_we), .ram_addr(ram_addr),
      .ram_wdata(ram_wdata), .ram_rdata(ram_rdata)
   );

   knn_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );
endmodule : knn_1d_vote_classifier
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 1-D nearest-neighbor vote classifier
// Drives inserts and queries over the request channel, predicts each verdict
// from a sorted table kept here, and compares every response field.
// ----------------------------------------------------------------------------
module tb;
   import knn_pkg::*;

   localparam int Capacity  = 256;
   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic [OpBits-1:0]    op;
      logic signed [31:0]   value;
      logic [LabelBits-1:0] label;
   } req_item_type;

   typedef struct packed {
      logic [LabelBits-1:0]  outcome;
      logic [StatusBits-1:0] status;
      logic [CountBits-1:0]  count;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [KBits-1:0] csr_wdata = '0;

   knn_req_if #(.VALUE_BITS(32)) req ();
   knn_rsp_if rsp ();

   knn_1d_vote_classifier #(.CAPACITY(Capacity), .VALUE_BITS(32)) dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   // Shadow table, sorted by value then label.
   logic signed [31:0]   tbl_value [Capacity];
   logic [LabelBits-1:0] tbl_label [Capacity];
   int                   tbl_count;
   int                   k_setting;

   req_item_type pending_reqs[$];
   verdict_type  expected_verdicts[$];
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        mismatches = 0;
   int        watch = 0;

   function automatic bit sorts_below(int i, logic signed [31:0] v, logic [1:0] l);
      if (tbl_value[i] != v) return tbl_value[i] < v;
      return tbl_label[i] < l;
   endfunction

   function automatic int first_not_below(logic signed [31:0] v, logic [1:0] l);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (sorts_below(mid, v, l)) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic longint distance(logic signed [31:0] a, logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d < 0 ? -d : d;
   endfunction

   function automatic logic [1:0] vote(logic signed [31:0] v);
      int pos;
      int lft;
      int rgt;
      int pick;
      int fails;
      fails = 0;
      if (tbl_count == 0 || k_setting > tbl_count) return LABEL_UNKNOWN;
      pos = first_not_below(v, LABEL_UNKNOWN);
      if (pos == tbl_count) begin
         lft = tbl_count - 1;
         rgt = tbl_count;
      end else begin
         lft = pos;
         rgt = pos + 1;
      end
      for (int t = 0; t < k_setting; t++) begin
         if (lft < 0 && rgt >= tbl_count) break;
         if (lft < 0) begin
            pick = rgt;
            rgt = rgt + 1;
         end else if (rgt >= tbl_count) begin
            pick = lft;
            lft = lft - 1;
         end else if (distance(v, tbl_value[lft]) < distance(v, tbl_value[rgt])) begin
            pick = lft;
            lft = lft - 1;
         end else begin
            pick = rgt;
            rgt = rgt + 1;
         end
         if (tbl_label[pick] == LABEL_FAIL) fails++;
      end
      if (fails * 2 > k_setting) return LABEL_FAIL;
      if (fails * 2 < k_setting) return LABEL_PASS;
      return LABEL_UNKNOWN;
   endfunction

   function automatic verdict_type predict_verdict(req_item_type it);
      verdict_type r;
      int pos;
      r.outcome = LABEL_UNKNOWN;
      r.status = ST_OK;
      if (it.op == OP_CLASSIFY) begin
         r.outcome = vote(it.value);
      end else begin
         pos = first_not_below(it.value, it.label);
         if (pos < tbl_count && tbl_value[pos] == it.value && tbl_label[pos] == it.label)
            r.status = ST_DUP;
         else if (tbl_count >= Capacity)
            r.status = ST_FULL;
         else begin
            for (int i = tbl_count; i > pos; i--) begin
               tbl_value[i] = tbl_value[i-1];
               tbl_label[i] = tbl_label[i-1];
            end
            tbl_value[pos] = it.value;
            tbl_label[pos] = it.label;
            tbl_count++;
         end
      end
      r.count = tbl_count[CountBits-1:0];
      return r;
   endfunction

   function automatic void queue_req(req_item_type it);
      pending_reqs = {pending_reqs, it};
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // Driver: a transfer happens when valid and ready meet at an edge.
   initial begin
      req.valid = 1'b0;
      req.op = OP_INSERT;
      req.sample_value = '0;
      req.sample_label = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_verdicts = {expected_verdicts, predict_verdict(pending_reqs.pop_front())};
         end
         if ((!req.valid || req.ready) ) begin
            if (pending_reqs.size() > (req.valid && req.ready ? 1 : 0) - (req.valid && req.ready ? 1 : 0)
                && pending_reqs.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
               req.valid        <= 1'b1;
               req.op           <= pending_reqs[0].op;
               req.sample_value <= pending_reqs[0].value;
               req.sample_label <= pending_reqs[0].label;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   initial rsp.ready = 1'b0;

   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response transfer: %0d/%0d/%0d",
                                              rsp.outcome, rsp.status, rsp.entry_count);
            end else begin
               exp_v = expected_verdicts.pop_front();
               if (rsp.outcome !== exp_v.outcome || rsp.status !== exp_v.status ||
                   rsp.entry_count !== exp_v.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Response mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              exp_v.outcome, exp_v.status, exp_v.count,
                              rsp.outcome, rsp.status, rsp.entry_count);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WatchLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic signed [31:0] near_value();
      // Small value pool so duplicates and ties happen often.
      return 32'sd65536 * ($urandom_range(40) - 20) + ($urandom_range(1) ? 32'sd32768 : 0);
   endfunction

   function automatic logic signed [31:0] wide_value();
      return $urandom_range(3) == 0 ? $urandom() : near_value();
   endfunction

   function automatic req_item_type make_req(logic [OpBits-1:0] op,
                                             logic signed [31:0] v, logic [1:0] l);
      req_item_type it;
      it.op = op;
      it.value = v;
      it.label = l;
      return it;
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || req.valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_k(int k);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= k[KBits-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      k_setting = k;
   endtask

   task automatic random_burst(int n, int ins_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < ins_pct)
            queue_req(make_req(OP_INSERT, wide_value(), 2'($urandom_range(3))));
         else
            queue_req(make_req(OP_CLASSIFY, wide_value(), 2'($urandom_range(3))));
      end
   endtask

   initial begin
      k_setting = int'(KReset);
      tbl_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, duplicates, label code 3, k above count.
      queue_req(make_req(OP_CLASSIFY, 32'sh0, LABEL_PASS));
      queue_req(make_req(OP_INSERT, 32'sh8000_0000, LABEL_FAIL));
      queue_req(make_req(OP_INSERT, 32'sh7FFF_FFFF, LABEL_PASS));
      queue_req(make_req(OP_CLASSIFY, 32'sh0, LABEL_FAIL));
      queue_req(make_req(OP_INSERT, 32'sh7FFF_FFFF, LABEL_PASS));
      queue_req(make_req(OP_INSERT, 32'sh0, 2'd3));
      queue_req(make_req(OP_INSERT, 32'sh0, LABEL_UNKNOWN));
      queue_req(make_req(OP_INSERT, 32'sh0, LABEL_FAIL));
      queue_req(make_req(OP_CLASSIFY, 32'sh8000_0000, 2'd3));
      queue_req(make_req(OP_CLASSIFY, 32'sh7FFF_FFFF, LABEL_PASS));
      queue_req(make_req(OP_CLASSIFY, 32'sh0, LABEL_PASS));
      queue_req(make_req(OP_CLASSIFY, 32'shFFFF_FFFF, LABEL_PASS));
      drain();
      set_k(15);
      queue_req(make_req(OP_CLASSIFY, 32'sh1, LABEL_PASS));
      drain();
      set_k(0);
      queue_req(make_req(OP_CLASSIFY, 32'sh1, LABEL_PASS));
      drain();
      set_k(1);
      queue_req(make_req(OP_CLASSIFY, 32'sh4000_0000, LABEL_PASS));
      queue_req(make_req(OP_CLASSIFY, -32'sh4000_0000, LABEL_PASS));

      // Random phases with differing idling and k.
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         set_k(ph == 7 ? 15 : $urandom_range(15));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         random_burst(55, 60);
      end

      // Fill the table past capacity, then query it full.
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
      set_k(7);
      while (tbl_count + pending_reqs.size() < Capacity + 20) begin
         queue_req(make_req(OP_INSERT, $urandom(), 2'($urandom_range(3))));
         @(posedge clock);
      end
      drain();
      queue_req(make_req(OP_INSERT, tbl_value[0], tbl_label[0]));
      queue_req(make_req(OP_INSERT, 32'sh8000_0000, LABEL_FAIL));
      random_burst(60, 0);
      drain();
      set_k(15);
      random_burst(60, 20);
      drain();

      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule : tb
